[rtl/core/next_digit_permutation_core_macros.svh]
// Assertion macros for the checker file of next_digit_permutation_core.
// Depends on nothing; include by bare file name.
`ifndef NEXT_DIGIT_PERMUTATION_CORE_MACROS_SVH
`define NEXT_DIGIT_PERMUTATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ndp assertion failed");

// Plain invariant, disabled while reset is asserted.
`define NDP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("ndp invariant failed");

`endif

[rtl/core/ndp_pkg.sv]
// Shared types and constants for the next digit permutation core.
// No dependencies.
`default_nettype none

package ndp_pkg;

    localparam int MAX_DIGITS = 15;
    localparam int OUT_DIGITS = MAX_DIGITS + 1;
    localparam int NIB_W      = 4;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int OCNT_W     = $clog2(OUT_DIGITS + 1);
    localparam int POS_W      = $clog2(OUT_DIGITS);
    localparam int DIN_W      = MAX_DIGITS * NIB_W;
    localparam int DOUT_W     = OUT_DIGITS * NIB_W;

    localparam logic [NIB_W-1:0] DIGIT_MAX = 4'd9;

    typedef logic [NIB_W-1:0] t_nib;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_NONZERO = 2'd1,
        ST_BAD_BCD    = 2'd2
    } t_status;

    // per-position findings of one lane
    typedef struct packed {
        logic bad;
        logic nonzero;
        logic desc;
    } t_lane_flags;

    // merged pivot decision handed to the build stage
    typedef struct packed {
        t_status          status;
        logic             grow;
        logic [POS_W-1:0] pos;
    } t_pivot;

endpackage

`default_nettype wire

[rtl/core/next_digit_permutation_core.sv]
// Top level of the next digit permutation core.
// Depends on ndp_pkg, ndp_lane, ndp_merge and ndp_build.
`default_nettype none

// Returns the next larger decimal number with the same nonzero digits (zeros
// free), from packed BCD and a digit count. A transfer in is taken on any
// clock edge with start high; busy is never raised, so one number may be
// given every cycle. Each result passes the stage 1 and output registers and
// is shown on the o_ ports for exactly one cycle with o_valid high; there is
// no way to hold it, so the receiver must take it in that cycle. The fifteen
// digit lanes and the pivot merge feed the stage 1 registers; the swap and
// reversal of the lower digits feed the output registers. Status 2 flags a
// nibble above 9 within the count, status 1 a number with no nonzero digit
// (count of zero included); either way digits and count read zero. With no
// larger arrangement the result grows by one digit.
module next_digit_permutation_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [ndp_pkg::DIN_W-1:0]         i_digits_in,
    input  wire [ndp_pkg::CNT_W-1:0]         i_digit_count,
    output logic                             o_valid,
    output logic [ndp_pkg::DOUT_W-1:0]       o_digits_out,
    output logic [ndp_pkg::OCNT_W-1:0]       o_out_count,
    output logic [1:0]                       o_status
);

    ndp_pkg::t_nib        lane_digit [ndp_pkg::MAX_DIGITS];
    ndp_pkg::t_lane_flags lane_flags [ndp_pkg::MAX_DIGITS];
    ndp_pkg::t_pivot      pivot;

    // stage 1 registers
    logic                      r_vld1;
    ndp_pkg::t_nib             r_dig [ndp_pkg::MAX_DIGITS];
    logic [ndp_pkg::CNT_W-1:0] r_cnt;
    ndp_pkg::t_pivot           r_piv;

    // stage 2 (output) registers
    logic                       r_vld2;
    logic [ndp_pkg::DOUT_W-1:0] r_dout;
    logic [ndp_pkg::OCNT_W-1:0] r_ocnt;
    ndp_pkg::t_status           r_status;

    logic [ndp_pkg::DOUT_W-1:0] n_dout;
    logic [ndp_pkg::OCNT_W-1:0] n_ocnt;
    ndp_pkg::t_status           n_status;

    assign busy = 1'b0;

    // one lane per input digit; lane 0 has nothing below it
    for (genvar k = 0; k < ndp_pkg::MAX_DIGITS; k++) begin : g_lane
        if (k == 0) begin : g_first
            ndp_lane u_lane (
                .i_digit   (i_digits_in[k*ndp_pkg::NIB_W +: ndp_pkg::NIB_W]),
                .i_prev    (i_digits_in[k*ndp_pkg::NIB_W +: ndp_pkg::NIB_W]),
                .i_in_range(ndp_pkg::CNT_W'(k) < i_digit_count),
                .o_digit   (lane_digit[k]),
                .o_flags   (lane_flags[k])
            );
        end else begin : g_rest
            ndp_lane u_lane (
                .i_digit   (i_digits_in[k*ndp_pkg::NIB_W +: ndp_pkg::NIB_W]),
                .i_prev    (i_digits_in[(k-1)*ndp_pkg::NIB_W +: ndp_pkg::NIB_W]),
                .i_in_range(ndp_pkg::CNT_W'(k) < i_digit_count),
                .o_digit   (lane_digit[k]),
                .o_flags   (lane_flags[k])
            );
        end
    end

    ndp_merge u_merge (
        .i_flags(lane_flags),
        .i_count(i_digit_count),
        .o_pivot(pivot)
    );

    // control: a transfer walks through two valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= start && !busy;
            r_vld2 <= r_vld1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_dig <= lane_digit;
        r_cnt <= i_digit_count;
        r_piv <= pivot;
    end

    ndp_build u_build (
        .i_digits    (r_dig),
        .i_count     (r_cnt),
        .i_pivot     (r_piv),
        .o_digits_out(n_dout),
        .o_out_count (n_ocnt),
        .o_status    (n_status)
    );

    always_ff @(posedge i_clk) begin
        r_dout   <= n_dout;
        r_ocnt   <= n_ocnt;
        r_status <= n_status;
    end

    assign o_valid      = r_vld2;
    assign o_digits_out = r_dout;
    assign o_out_count  = r_ocnt;
    assign o_status     = r_status;

endmodule

`default_nettype wire

[rtl/core/ndp_lane.sv]
// One digit lane: range mask, BCD check, nonzero and descent detection.
// Depends on ndp_pkg.
`default_nettype none

module ndp_lane (
    input  wire ndp_pkg::t_nib        i_digit,
    input  wire ndp_pkg::t_nib        i_prev,
    input  wire                       i_in_range,
    output ndp_pkg::t_nib             o_digit,
    output ndp_pkg::t_lane_flags      o_flags
);

    assign o_digit         = i_in_range ? i_digit : '0;
    assign o_flags.bad     = i_in_range && (i_digit > ndp_pkg::DIGIT_MAX);
    assign o_flags.nonzero = i_in_range && (i_digit != '0);
    // digit below is larger: candidate pivot
    assign o_flags.desc    = i_in_range && (i_digit < i_prev);

endmodule

`default_nettype wire

[rtl/core/ndp_merge.sv]
// Merges lane findings: status, lowest descent position, or growth.
// Depends on ndp_pkg.
`default_nettype none

module ndp_merge (
    input  wire ndp_pkg::t_lane_flags           i_flags [ndp_pkg::MAX_DIGITS],
    input  wire [ndp_pkg::CNT_W-1:0]            i_count,
    output ndp_pkg::t_pivot                     o_pivot
);

    logic bad_any;
    logic nz_any;
    logic grow;
    logic [ndp_pkg::POS_W-1:0] pos;

    always_comb begin
        bad_any = 1'b0;
        nz_any  = 1'b0;
        grow    = 1'b1;
        pos     = ndp_pkg::POS_W'(i_count);
        for (int i = 0; i < ndp_pkg::MAX_DIGITS; i++) begin
            bad_any = bad_any | i_flags[i].bad;
            nz_any  = nz_any | i_flags[i].nonzero;
        end
        // lowest descent wins
        for (int i = ndp_pkg::MAX_DIGITS - 1; i > 0; i--) begin
            if (i_flags[i].desc) begin
                pos  = ndp_pkg::POS_W'(i);
                grow = 1'b0;
            end
        end
    end

    always_comb begin
        o_pivot.grow = grow;
        o_pivot.pos  = pos;
        if (bad_any) begin
            o_pivot.status = ndp_pkg::ST_BAD_BCD;
        end else if (!nz_any) begin
            o_pivot.status = ndp_pkg::ST_NO_NONZERO;
        end else begin
            o_pivot.status = ndp_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ndp_build.sv]
// Builds the result: swap at the pivot, reversed tail, growth digit.
// Depends on ndp_pkg.
`default_nettype none

module ndp_build (
    input  wire ndp_pkg::t_nib                 i_digits [ndp_pkg::MAX_DIGITS],
    input  wire [ndp_pkg::CNT_W-1:0]           i_count,
    input  wire ndp_pkg::t_pivot               i_pivot,
    output logic [ndp_pkg::DOUT_W-1:0]         o_digits_out,
    output logic [ndp_pkg::OCNT_W-1:0]         o_out_count,
    output ndp_pkg::t_status                   o_status
);

    ndp_pkg::t_nib d [ndp_pkg::OUT_DIGITS];
    ndp_pkg::t_nib s [ndp_pkg::OUT_DIGITS];
    ndp_pkg::t_nib x;
    ndp_pkg::t_nib dj;
    logic [ndp_pkg::POS_W-1:0] j;
    logic [ndp_pkg::DOUT_W-1:0] packed_out;

    // digits above the count are already zero, so the growth slot reads 0
    always_comb begin
        for (int i = 0; i < ndp_pkg::MAX_DIGITS; i++) begin
            d[i] = i_digits[i];
        end
        d[ndp_pkg::OUT_DIGITS-1] = '0;
    end

    // pivot digit and lowest lower position holding a larger digit
    always_comb begin
        x = '0;
        for (int i = 0; i < ndp_pkg::OUT_DIGITS; i++) begin
            if (ndp_pkg::POS_W'(i) == i_pivot.pos) begin
                x = d[i];
            end
        end
    end

    always_comb begin
        j = '0;
        for (int i = ndp_pkg::OUT_DIGITS - 1; i >= 0; i--) begin
            if ((ndp_pkg::POS_W'(i) < i_pivot.pos) && (d[i] > x)) begin
                j = ndp_pkg::POS_W'(i);
            end
        end
    end

    always_comb begin
        dj = '0;
        for (int i = 0; i < ndp_pkg::OUT_DIGITS; i++) begin
            if (ndp_pkg::POS_W'(i) == j) begin
                dj = d[i];
            end
            s[i] = (ndp_pkg::POS_W'(i) == j) ? x : d[i];
        end
    end

    // tail below the pivot is ascending upward; write it reversed
    always_comb begin
        logic [ndp_pkg::POS_W-1:0] idx;
        ndp_pkg::t_nib             v;
        packed_out = '0;
        for (int k = 0; k < ndp_pkg::OUT_DIGITS; k++) begin
            idx = i_pivot.pos - ndp_pkg::POS_W'(1) - ndp_pkg::POS_W'(k);
            v   = '0;
            if (ndp_pkg::POS_W'(k) > i_pivot.pos) begin
                v = d[k];
            end else if (ndp_pkg::POS_W'(k) == i_pivot.pos) begin
                v = dj;
            end else begin
                for (int i = 0; i < ndp_pkg::OUT_DIGITS; i++) begin
                    if (ndp_pkg::POS_W'(i) == idx) begin
                        v = s[i];
                    end
                end
            end
            packed_out[k*ndp_pkg::NIB_W +: ndp_pkg::NIB_W] = v;
        end
    end

    always_comb begin
        o_status = i_pivot.status;
        if (i_pivot.status == ndp_pkg::ST_OK) begin
            o_digits_out = packed_out;
            o_out_count  = ndp_pkg::OCNT_W'(i_count) + ndp_pkg::OCNT_W'(i_pivot.grow);
        end else begin
            o_digits_out = '0;
            o_out_count  = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ndp_checker.sv]
// Port-level checks for next_digit_permutation_core, bound to the top level.
// Depends on ndp_pkg and next_digit_permutation_core_macros.svh.
`default_nettype none

`include "next_digit_permutation_core_macros.svh"

module ndp_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              start,
    input wire                              busy,
    input wire [ndp_pkg::CNT_W-1:0]         i_digit_count,
    input wire                              o_valid,
    input wire [ndp_pkg::DOUT_W-1:0]        o_digits_out,
    input wire [ndp_pkg::OCNT_W-1:0]        o_out_count,
    input wire [1:0]                        o_status
);

    wire took_in  = start && !busy && i_rst_n;
    wire err_res  = o_valid && (o_status != ndp_pkg::ST_OK);
    wire ok_res   = o_valid && (o_status == ndp_pkg::ST_OK);
    wire zero_res = (o_digits_out == '0) && (o_out_count == '0);
    wire [ndp_pkg::OCNT_W-1:0] cnt_in = ndp_pkg::OCNT_W'(i_digit_count);

    // never stalls the sender
    `NDP_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy)

    // o_valid tracks the delayed transfer, one strobe per transfer
    `NDP_ASSERT_IMPL(a_latency, i_clk, i_rst_n, $past(i_rst_n, 1), o_valid == $past(took_in, 2))

    // error results carry no digits
    `NDP_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, err_res, zero_res)

    // good results keep the count or grow it by one
    `NDP_ASSERT_IMPL(a_ok_count, i_clk, i_rst_n, ok_res, (o_out_count - $past(cnt_in, 2)) < 5'd2)

endmodule

bind next_digit_permutation_core ndp_checker u_ndp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_digit_count(i_digit_count),
    .o_valid      (o_valid),
    .o_digits_out (o_digits_out),
    .o_out_count  (o_out_count),
    .o_status     (o_status)
);

`default_nettype wire

[sim/next_digit_permutation_core_test.sv]
// Self-checking testbench for next_digit_permutation_core: directed and random BCD numbers
// against a behavioural predictor of the next digit arrangement.
// Depends on ndp_pkg and next_digit_permutation_core.
`timescale 1ns / 100ps

module next_digit_permutation_core_test;

    // expected content of one result transfer
    typedef struct packed {
        logic [ndp_pkg::DOUT_W-1:0] digits;
        logic [ndp_pkg::OCNT_W-1:0] count;
        ndp_pkg::t_status           status;
    } t_next_number;

    // Predicts the next arrangement per input transfer and checks results in order.
    class permutation_scoreboard;
        t_next_number pending[$];
        int           errors;

        // next larger number with the same nonzero digits, zeros free
        function t_next_number next_arrangement(logic [ndp_pkg::DIN_W-1:0] din,
                                                logic [ndp_pkg::CNT_W-1:0] cnt);
            t_next_number               r;
            logic [3:0]                 d[ndp_pkg::MAX_DIGITS];
            int                         tally[10];
            int                         n, top, pivot, repl;
            bit                         bad, nonzero;
            logic [ndp_pkg::DOUT_W-1:0] acc;
            r       = '0;
            n       = int'(cnt);
            bad     = 1'b0;
            nonzero = 1'b0;
            if (n > ndp_pkg::MAX_DIGITS) begin
                n = ndp_pkg::MAX_DIGITS;
            end
            for (int p = 0; p < n; p++) begin
                d[p] = din[4*p +: 4];
                if (d[p] > ndp_pkg::DIGIT_MAX) begin
                    bad = 1'b1;
                end else if (d[p] != 4'd0) begin
                    nonzero = 1'b1;
                end
            end
            // a bad nibble outranks an all-zero number; both give zero fields
            if (bad) begin
                r.status = ndp_pkg::ST_BAD_BCD;
                return r;
            end
            if (!nonzero) begin
                r.status = ndp_pkg::ST_NO_NONZERO;
                return r;
            end
            tally = '{default: 0};
            pivot = -1;
            repl  = 0;
            // walk up from the low end; first digit with a larger one below is the pivot
            for (int p = 0; p < n && pivot < 0; p++) begin
                tally[d[p]]++;
                for (int v = int'(d[p]) + 1; v < 10 && pivot < 0; v++) begin
                    if (tally[v] > 0) begin
                        pivot = p;
                        repl  = v;
                    end
                end
            end
            acc = '0;
            if (pivot >= 0) begin
                tally[repl]--;
                for (int q = pivot + 1; q < n; q++) begin
                    acc[4*q +: 4] = d[q];
                end
                acc[4*pivot +: 4] = repl[3:0];
                top     = pivot;
                r.count = ndp_pkg::OCNT_W'(n);
            end else begin
                // already the largest: smallest nonzero digit on top, one extra zero
                repl = 1;
                while (tally[repl] == 0) begin
                    repl++;
                end
                tally[repl]--;
                tally[0]++;
                acc[4*n +: 4] = repl[3:0];
                top     = n;
                r.count = ndp_pkg::OCNT_W'(n + 1);
            end
            // remaining digits ascending from the top of the tail downwards
            for (int v = 0; v < 10; v++) begin
                while (tally[v] > 0 && top > 0) begin
                    top--;
                    acc[4*top +: 4] = v[3:0];
                    tally[v]--;
                end
            end
            r.digits = acc;
            r.status = ndp_pkg::ST_OK;
            return r;
        endfunction

        function void note_transfer(logic [ndp_pkg::DIN_W-1:0] din,
                                    logic [ndp_pkg::CNT_W-1:0] cnt);
            pending = {pending, next_arrangement(din, cnt)};
        endfunction

        function void report_mismatch(string what, logic [63:0] exp_val, logic [63:0] act_val);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, what, exp_val, act_val);
        endfunction

        function void check_result(logic [ndp_pkg::DOUT_W-1:0] digits,
                                   logic [ndp_pkg::OCNT_W-1:0] count,
                                   logic [1:0] status);
            t_next_number exp_num;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, digits", '0, 64'(digits));
                return;
            end
            exp_num = pending.pop_front();
            if (status !== exp_num.status) begin
                report_mismatch("status", 64'(exp_num.status), 64'(status));
            end
            if (count !== exp_num.count) begin
                report_mismatch("digit count", 64'(exp_num.count), 64'(count));
            end
            if (digits !== exp_num.digits) begin
                report_mismatch("digits", 64'(exp_num.digits), 64'(digits));
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic [ndp_pkg::DIN_W-1:0]  digits_in;
    logic [ndp_pkg::CNT_W-1:0]  digit_count;
    logic                       busy;
    logic                       o_valid;
    logic [ndp_pkg::DOUT_W-1:0] o_digits_out;
    logic [ndp_pkg::OCNT_W-1:0] o_out_count;
    logic [1:0]                 o_status;

    permutation_scoreboard sb;

    next_digit_permutation_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_digits_in   (digits_in),
        .i_digit_count (digit_count),
        .o_valid       (o_valid),
        .o_digits_out  (o_digits_out),
        .o_out_count   (o_out_count),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // Everything is sampled at the rising edge; inputs only move at the falling edge.
    // The input transfer is noted before the result check so ordering holds at any latency.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_transfer(digits_in, digit_count);
            end
            if (o_valid) begin
                sb.check_result(o_digits_out, o_out_count, o_status);
            end
        end
    end

    // Offer one number and hold it until the block takes it.
    task automatic send_number(input logic [ndp_pkg::DIN_W-1:0] din,
                               input logic [ndp_pkg::CNT_W-1:0] cnt);
        @(negedge i_clk);
        start       <= 1'b1;
        digits_in   <= din;
        digit_count <= cnt;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic hold_off();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Random number: mostly well-formed BCD, plus largest arrangements (growth),
    // bad nibbles, all-zero numbers and raw noise. Nibbles above the count are junk half the time.
    task automatic pick_number(output logic [ndp_pkg::DIN_W-1:0] din,
                               output logic [ndp_pkg::CNT_W-1:0] cnt);
        logic [63:0] raw;
        int          kind, n, prev, spot;
        raw  = {$urandom, $urandom};
        din  = raw[ndp_pkg::DIN_W-1:0];
        kind = $urandom_range(0, 99);
        n    = $urandom_range(1, ndp_pkg::MAX_DIGITS);
        if ($urandom_range(0, 1) == 0) begin
            for (int p = n; p < ndp_pkg::MAX_DIGITS; p++) begin
                din[4*p +: 4] = 4'd0;
            end
        end
        if (kind < 60) begin
            for (int p = 0; p < n; p++) begin
                din[4*p +: 4] = ($urandom_range(0, 99) < 25) ? 4'd0 : 4'($urandom_range(0, 9));
            end
        end else if (kind < 72) begin
            // non-increasing from the top: no larger arrangement exists
            prev = 9;
            for (int p = n - 1; p >= 0; p--) begin
                prev          = $urandom_range(0, prev);
                din[4*p +: 4] = 4'(prev);
            end
        end else if (kind < 82) begin
            for (int p = 0; p < n; p++) begin
                din[4*p +: 4] = 4'($urandom_range(0, 9));
            end
            spot             = $urandom_range(0, n - 1);
            din[4*spot +: 4] = 4'($urandom_range(10, 15));
        end else if (kind < 90) begin
            for (int p = 0; p < n; p++) begin
                din[4*p +: 4] = 4'd0;
            end
        end else if (kind < 93) begin
            n = 0;
        end else begin
            n = $urandom_range(0, ndp_pkg::MAX_DIGITS);
        end
        cnt = n[ndp_pkg::CNT_W-1:0];
    endtask

    initial begin
        int                        idle_pct[4];
        int                        waited;
        logic [ndp_pkg::DIN_W-1:0] din;
        logic [ndp_pkg::CNT_W-1:0] cnt;
        idle_pct    = '{0, 45, 0, 24};
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        digits_in   = '0;
        digit_count = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, growth, leading zeros, bad and empty numbers
        send_number('0, 4'd0);
        send_number({ndp_pkg::DIN_W{1'b1}}, 4'd0);
        send_number({ndp_pkg::DIN_W{1'b1}}, 4'd15);
        send_number(60'h5, 4'd1);
        send_number(60'h0, 4'd1);
        send_number(60'h999999999999999, 4'd15);
        send_number(60'h987654321000000, 4'd15);
        send_number(60'h123456789012345, 4'd15);
        send_number(60'h21, 4'd2);
        send_number(60'h12, 4'd2);
        send_number(60'h0012, 4'd4);
        send_number(60'h0021, 4'd4);
        send_number(60'hA23, 4'd3);
        send_number(60'hF23, 4'd2);
        send_number(60'hFFF000, 4'd3);
        send_number(60'h0B0, 4'd3);
        send_number(60'h999999999999999, 4'd14);
        send_number(60'h100, 4'd3);
        send_number(60'h5, 4'd15);
        send_number(60'h90, 4'd2);
        send_number(60'h909, 4'd3);
        send_number(60'h777, 4'd3);
        send_number(60'hF99999999999999, 4'd15);

        // random phases: back to back, sender gaps 45 %, back to back, sender gaps 24 %
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 400; k++) begin
                while ($urandom_range(0, 99) < idle_pct[ph]) begin
                    hold_off();
                end
                pick_number(din, cnt);
                send_number(din, cnt);
            end
        end
        hold_off();

        // drain: wait for every noted transfer to produce its result
        waited = 0;
        while (sb.pending.size() != 0 && waited < 100) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d transfers never produced a result", $time, sb.pending.size());
        end
        if (sb.errors == 0) begin
            $display("next_digit_permutation_core_test: clean");
        end else begin
            $display("next_digit_permutation_core_test: errors");
        end
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("next_digit_permutation_core_test: errors");
        $finish;
    end

endmodule
